@@ rtl/salc_pkg.sv @@
`timescale 1ns / 1ps
package salc_pkg;
   typedef enum logic [3:0] {
      ST_IDLE, ST_SEARCH_RD, ST_SEARCH, ST_VICTIM, ST_FREE_RD, ST_FREE,
      ST_SHIFT_RD, ST_SHIFT_WR, ST_FRONT, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OUT_MAIN_HIT = 2'd0, OUT_VICTIM_HIT = 2'd1, OUT_MISS = 2'd2
   } outcome_type;

   localparam logic [1:0] REG_OFFSET = 2'd0;
   localparam logic [1:0] REG_INDEX  = 2'd1;
   localparam logic [1:0] REG_WAYS   = 2'd2;
   localparam logic [1:0] REG_VICTIM = 2'd3;
endpackage

@@ rtl/set_assoc_lru_cache_with_victim_top.sv @@
`timescale 1ns / 1ps
// The single line-store read port paces each access: it searches, then shifts, one way at a time,
// reading in one state and comparing or writing in a second; a miss also searches for a free way.
// busy drops in the cycle after the result, so a new access is taken only after the result.
// One result per access, shown for one cycle with rsp_valid; the receiver cannot stall.
// Synchronous reset clears control, counters and registers; a clearing pass then runs over
// every line of the line store.
module set_assoc_lru_cache_with_victim_top #(
   parameter int MAX_LINES    = 256,
   parameter int MAX_WAYS     = 8,
   parameter int VICTIM_DEPTH = 8,
   parameter int ADDR_WIDTH   = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [47:0] req_address,
   output logic        rsp_valid,
   output logic [1:0]  rsp_outcome,
   output logic [31:0] rsp_request_total,
   output logic [31:0] rsp_miss_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);
   import salc_pkg::*;

   localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int VW = (VICTIM_DEPTH > 1) ? $clog2(VICTIM_DEPTH) : 1;
   localparam int AW = ADDR_WIDTH;

   // configuration
   logic [4:0] off_reg_ff;
   logic [3:0] idx_reg_ff, ways_reg_ff, vic_reg_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         off_reg_ff <= 5'd4; idx_reg_ff <= 4'd4; ways_reg_ff <= 4'd4; vic_reg_ff <= 4'd0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_OFFSET: off_reg_ff  <= csr_data;
            REG_INDEX:  idx_reg_ff  <= csr_data[3:0];
            REG_WAYS:   ways_reg_ff <= csr_data[3:0];
            REG_VICTIM: vic_reg_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   logic [4:0] off_sat;
   logic [3:0] idx_sat;
   logic [4:0] nw, vl, tsh;
   always_comb begin
      off_sat = (off_reg_ff > 5'd16) ? 5'd16 : off_reg_ff;
      idx_sat = (idx_reg_ff > 4'd8) ? 4'd8 : idx_reg_ff;
      tsh     = off_sat + {1'b0, idx_sat};
      if (ways_reg_ff == 4'd0) nw = 5'd1;
      else if (32'(ways_reg_ff) > MAX_WAYS) nw = 5'(MAX_WAYS);
      else nw = {1'b0, ways_reg_ff};
      vl = (32'(vic_reg_ff) > VICTIM_DEPTH) ? 5'(VICTIM_DEPTH) : {1'b0, vic_reg_ff};
   end

   // line store: one read, one write port
   logic [AW-1:0] mem_addr [MAX_LINES];
   logic          mem_vld  [MAX_LINES];
   logic [LW-1:0] rd_idx, wr_idx;
   logic          wr_en;
   logic [AW-1:0] wr_a;
   logic          wr_v;
   logic [AW-1:0] rd_a_ff;
   logic          rd_v_ff;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_addr[wr_idx] <= wr_a;
         mem_vld[wr_idx]  <= wr_v;
      end
      rd_a_ff <= mem_addr[rd_idx];
      rd_v_ff <= mem_vld[rd_idx];
   end

   // victim list in flip-flops
   logic [AW-1:0] vic_a_ff [VICTIM_DEPTH];
   logic          vic_v_ff [VICTIM_DEPTH];

   state_type     state_ff, state_in;
   logic [LW:0]   clr_ff;
   logic [AW-1:0] addr_ff;
   logic [LW-1:0] base_ff;
   logic [4:0]    w_ff, w_in, tgt_ff, tgt_in;
   logic [1:0]    out_ff, out_in;
   logic [31:0]   req_cnt_ff, miss_cnt_ff;
   logic          push_ff, push_in;
   logic [AW-1:0] evict_ff, evict_in;

   logic [AW-1:0] req_a;
   logic [7:0]    set_num;
   logic [LW+8:0] base_full;
   assign req_a = AW'(req_address);
   always_comb begin
      set_num   = 8'((req_a >> off_sat) & AW'((1 << idx_sat) - 1));
      base_full = (LW+9)'(set_num) * (LW+9)'(nw);
   end

   function automatic logic [LW-1:0] slot(input logic [LW-1:0] b, input logic [4:0] w);
      logic [LW+5:0] s;
      s = (LW+6)'(b) + (LW+6)'(w);
      return LW'(s % MAX_LINES);
   endfunction

   logic tag_eq;
   assign tag_eq = rd_v_ff && ((rd_a_ff >> tsh) == (addr_ff >> tsh));

   // victim search: first valid match below vl
   logic          v_hit;
   logic [VW-1:0] v_pos;
   always_comb begin
      v_hit = 1'b0; v_pos = '0;
      for (int i = VICTIM_DEPTH - 1; i >= 0; i--)
         if (i < 32'(vl) && vic_v_ff[i] && ((vic_a_ff[i] >> off_sat) == (addr_ff >> off_sat))) begin
            v_hit = 1'b1; v_pos = VW'(i);
         end
   end

   // sequencer
   always_comb begin
      state_in = state_ff; w_in = w_ff; tgt_in = tgt_ff; out_in = out_ff;
      push_in = push_ff; evict_in = evict_ff;
      rd_idx = slot(base_ff, w_ff); wr_en = 1'b0; wr_idx = slot(base_ff, w_ff);
      wr_a = rd_a_ff; wr_v = rd_v_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!clr_ff[LW]) begin
               wr_en = 1'b1; wr_idx = clr_ff[LW-1:0]; wr_a = '0; wr_v = 1'b0;
            end else if (start) begin
               w_in = '0; push_in = 1'b0; state_in = ST_SEARCH_RD;
            end
         end
         ST_SEARCH_RD: state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (tag_eq) begin
               out_in = OUT_MAIN_HIT; tgt_in = w_ff; state_in = ST_SHIFT_RD;
            end else if (w_ff + 5'd1 < nw) begin
               w_in = w_ff + 5'd1; state_in = ST_SEARCH_RD;
            end else begin
               evict_in = rd_a_ff; state_in = ST_VICTIM;
            end
         end
         ST_VICTIM: begin
            out_in = v_hit ? OUT_VICTIM_HIT : OUT_MISS;
            w_in = '0; state_in = ST_FREE_RD;
         end
         ST_FREE_RD: state_in = ST_FREE;
         ST_FREE: begin
            if (!rd_v_ff) begin
               tgt_in = w_ff; state_in = ST_SHIFT_RD;
            end else if (w_ff + 5'd1 < nw) begin
               w_in = w_ff + 5'd1; state_in = ST_FREE_RD;
            end else begin
               tgt_in = nw - 5'd1; push_in = (vl != 5'd0); state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            // read way tgt-1, to be moved into way tgt
            if (tgt_ff == 5'd0) state_in = ST_FRONT;
            else begin
               rd_idx = slot(base_ff, tgt_ff - 5'd1); state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en = 1'b1; wr_idx = slot(base_ff, tgt_ff);
            tgt_in = tgt_ff - 5'd1; state_in = ST_SHIFT_RD;
         end
         ST_FRONT: begin
            wr_en = 1'b1; wr_idx = base_ff; wr_a = addr_ff; wr_v = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; clr_ff <= '0; req_cnt_ff <= '0; miss_cnt_ff <= '0;
         for (int i = 0; i < VICTIM_DEPTH; i++) begin
            vic_a_ff[i] <= '0; vic_v_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (!clr_ff[LW]) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_IDLE && clr_ff[LW] && start) begin
            addr_ff <= req_a;
            base_ff <= LW'(base_full % MAX_LINES);
            req_cnt_ff <= req_cnt_ff + 32'd1;
         end
         // victim take: compact entries above the hit
         if (state_ff == ST_VICTIM) begin
            if (v_hit) begin
               for (int j = 0; j < VICTIM_DEPTH; j++)
                  if (j >= 32'(v_pos) && j + 1 < 32'(vl)) begin
                     vic_a_ff[j] <= vic_a_ff[(j + 1) % VICTIM_DEPTH];
                     vic_v_ff[j] <= vic_v_ff[(j + 1) % VICTIM_DEPTH];
                  end else if (j + 1 == 32'(vl)) begin
                     vic_a_ff[j] <= '0; vic_v_ff[j] <= 1'b0;
                  end
            end else miss_cnt_ff <= miss_cnt_ff + 32'd1;
         end
         // push the evicted line to the front of the victim list
         if (state_ff == ST_FRONT && push_ff) begin
            for (int j = 1; j < VICTIM_DEPTH; j++)
               if (j < 32'(vl)) begin
                  vic_a_ff[j] <= vic_a_ff[j - 1]; vic_v_ff[j] <= vic_v_ff[j - 1];
               end
            vic_a_ff[0] <= evict_ff; vic_v_ff[0] <= 1'b1;
         end
      end
      w_ff <= w_in; tgt_ff <= tgt_in; out_ff <= out_in;
      push_ff <= push_in; evict_ff <= evict_in;
   end

   assign busy              = (state_ff != ST_IDLE) || !clr_ff[LW];
   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_outcome       = out_ff;
   assign rsp_request_total = req_cnt_ff;
   assign rsp_miss_total    = miss_cnt_ff;

   a_no_start: assert property (@(posedge clock) disable iff (reset)
      !clr_ff[LW] |-> state_ff == ST_IDLE) else $error("access during clear");
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_front: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FRONT |=> rsp_valid) else $error("front write without response");
   a_miss_le: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_MISS |-> miss_cnt_ff != $past(miss_cnt_ff, 1) ||
      $past(state_ff, 1) != ST_VICTIM) else $error("miss not counted");
endmodule

@@ sim/set_assoc_lru_cache_with_victim_checker.sv @@
`timescale 1ns / 1ps
module set_assoc_lru_cache_with_victim_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [47:0] req_address,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_outcome,
   input  logic [31:0] rsp_request_total,
   input  logic [31:0] rsp_miss_total,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data,
   output int          fail_count,
   output int          pending
);
   import salc_pkg::*;

   typedef struct packed {
      outcome_type outcome;
      logic [31:0] request_total;
      logic [31:0] miss_total;
   } access_result_type;

   localparam int LINES  = 256;
   localparam int WAYS   = 8;
   localparam int VDEPTH = 8;

   // shadow copy of the cache contents and registers
   logic [47:0] line_addr [LINES];
   logic        line_vld  [LINES];
   logic [47:0] vic_addr  [VDEPTH];
   logic        vic_vld   [VDEPTH];
   logic [31:0] req_cnt, miss_cnt;
   logic [4:0]  cfg_offset;
   logic [3:0]  cfg_index, cfg_ways, cfg_victim;

   access_result_type expected_results[$];

   assign pending = expected_results.size();

   // shift ways 0..upto-1 down one slot and put addr at the front
   task automatic fill_front(input int base, input int upto, input logic [47:0] addr);
      int w;
      for (w = upto; w > 0; w--) begin
         line_addr[(base + w) % LINES] = line_addr[(base + w - 1) % LINES];
         line_vld[(base + w) % LINES]  = line_vld[(base + w - 1) % LINES];
      end
      line_addr[base % LINES] = addr;
      line_vld[base % LINES]  = 1'b1;
   endtask

   task automatic cache_access(input logic [47:0] addr, output access_result_type res);
      int off, idx, nw, vl, set_no, base, w, hit_way, free_way, i, j;
      logic [47:0] tag;
      logic vhit;
      off = (cfg_offset > 16) ? 16 : cfg_offset;
      idx = (cfg_index > 8) ? 8 : cfg_index;
      nw  = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : cfg_ways);
      vl  = (cfg_victim > VDEPTH) ? VDEPTH : cfg_victim;
      set_no = int'((addr >> off) & ((48'd1 << idx) - 48'd1));
      base = (set_no * nw) % LINES;
      tag = addr >> (off + idx);
      req_cnt++;
      hit_way = nw;
      for (w = 0; w < nw; w++) begin
         if (hit_way == nw && line_vld[(base + w) % LINES] &&
             (line_addr[(base + w) % LINES] >> (off + idx)) == tag)
            hit_way = w;
      end
      if (hit_way < nw) begin
         fill_front(base, hit_way, addr);
         res.outcome = OUT_MAIN_HIT;
      end else begin
         vhit = 1'b0;
         // search victims, remove the hit entry and compact
         for (i = 0; i < vl; i++) begin
            if (!vhit && vic_vld[i] && (vic_addr[i] >> off) == (addr >> off)) begin
               vhit = 1'b1;
               for (j = i; j + 1 < vl; j++) begin
                  vic_addr[j] = vic_addr[j + 1];
                  vic_vld[j]  = vic_vld[j + 1];
               end
               vic_addr[vl - 1] = '0;
               vic_vld[vl - 1]  = 1'b0;
            end
         end
         if (vhit) res.outcome = OUT_VICTIM_HIT;
         else begin
            res.outcome = OUT_MISS;
            miss_cnt++;
         end
         free_way = nw;
         for (w = 0; w < nw; w++)
            if (free_way == nw && !line_vld[(base + w) % LINES]) free_way = w;
         if (free_way < nw) fill_front(base, free_way, addr);
         else begin
            if (vl > 0) begin
               for (i = vl - 1; i > 0; i--) begin
                  vic_addr[i] = vic_addr[i - 1];
                  vic_vld[i]  = vic_vld[i - 1];
               end
               vic_addr[0] = line_addr[(base + nw - 1) % LINES];
               vic_vld[0]  = 1'b1;
            end
            fill_front(base, nw - 1, addr);
         end
      end
      res.request_total = req_cnt;
      res.miss_total    = miss_cnt;
   endtask

   // watch transfers on all three channels
   always @(posedge clock) begin
      access_result_type res, exp_res;
      if (reset) begin
         for (int k = 0; k < LINES; k++) begin
            line_addr[k] = '0;
            line_vld[k]  = 1'b0;
         end
         for (int k = 0; k < VDEPTH; k++) begin
            vic_addr[k] = '0;
            vic_vld[k]  = 1'b0;
         end
         req_cnt = '0;
         miss_cnt = '0;
         cfg_offset = 5'd4;
         cfg_index = 4'd4;
         cfg_ways = 4'd4;
         cfg_victim = 4'd0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing expected");
               fail_count++;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_outcome !== exp_res.outcome) begin
                  $error("outcome expected %0d actual %0d", exp_res.outcome, rsp_outcome);
                  fail_count++;
               end
               if (rsp_request_total !== exp_res.request_total) begin
                  $error("request_total expected %0d actual %0d",
                         exp_res.request_total, rsp_request_total);
                  fail_count++;
               end
               if (rsp_miss_total !== exp_res.miss_total) begin
                  $error("miss_total expected %0d actual %0d",
                         exp_res.miss_total, rsp_miss_total);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OFFSET: cfg_offset = csr_data;
               REG_INDEX:  cfg_index  = csr_data[3:0];
               REG_WAYS:   cfg_ways   = csr_data[3:0];
               REG_VICTIM: cfg_victim = csr_data[3:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            cache_access(req_address, res);
            expected_results.push_back(res);
         end
      end
   end
endmodule

@@ sim/set_assoc_lru_cache_with_victim_top_test.sv @@
`timescale 1ns / 1ps
module set_assoc_lru_cache_with_victim_top_test;
   import salc_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [47:0] req_address = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_outcome;
   logic [31:0] rsp_request_total, rsp_miss_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_OFFSET;
   logic [4:0]  csr_data = '0;
   int          fail_count, pending;
   int          idle_cycles = 0;

   logic [47:0] addr_pool[$];
   int          cur_off, cur_idx, cur_ways, cur_victim;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   set_assoc_lru_cache_with_victim_top dut (
      .clock, .reset, .start, .busy, .req_address,
      .rsp_valid, .rsp_outcome, .rsp_request_total, .rsp_miss_total,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   set_assoc_lru_cache_with_victim_checker checker_inst (
      .clock, .reset, .start, .busy, .req_address,
      .rsp_valid, .rsp_outcome, .rsp_request_total, .rsp_miss_total,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending
   );

   // end the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic logic [47:0] rand_addr();
      return 48'({$urandom(), $urandom()});
   endfunction

   // hold one access until the block takes it; start stays high afterwards
   task automatic send_access(input logic [47:0] addr);
      start = 1'b1;
      req_address = addr;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic pause(input int n);
      start = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_geometry(input int off, input int idx, input int nw, input int vl);
      drain();
      write_reg(REG_OFFSET, off[4:0]);
      write_reg(REG_INDEX, idx[4:0]);
      write_reg(REG_WAYS, nw[4:0]);
      write_reg(REG_VICTIM, vl[4:0]);
      cur_off = (off > 16) ? 16 : off;
      cur_idx = ((idx & 15) > 8) ? 8 : (idx & 15);
      cur_ways = ((nw & 15) == 0) ? 1 : (((nw & 15) > 8) ? 8 : (nw & 15));
      cur_victim = ((vl & 15) > 8) ? 8 : (vl & 15);
   endtask

   // addresses crowded into two sets so that lines get evicted and revisited
   function automatic logic [47:0] conflict_addr(input int set_no);
      logic [47:0] set_mask, a;
      set_mask = ((48'd1 << cur_idx) - 48'd1) << cur_off;
      a = rand_addr();
      return (a & ~set_mask) | ((48'(set_no) << cur_off) & set_mask);
   endfunction

   task automatic random_phase(input int count);
      int n, k, burst;
      logic [47:0] a, low_mask;
      addr_pool.delete();
      for (k = 0; k < 3 * cur_ways + cur_victim + 1; k++)
         addr_pool.push_back(conflict_addr($urandom_range(0, 1)));
      low_mask = (48'd1 << cur_off) - 48'd1;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 12);
         for (k = 0; k < burst && n < count; k++) begin
            if ($urandom_range(0, 9) == 0) a = rand_addr();
            else begin
               a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
               a = (a & ~low_mask) | (rand_addr() & low_mask);
            end
            send_access(a);
            n++;
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(0, 40));
      end
   endtask

   initial begin
      int p;
      cur_off = 4; cur_idx = 4; cur_ways = 4; cur_victim = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, reset geometry without victims
      send_access('0);
      send_access('1);
      send_access('1);
      send_access(48'h0000_0000_000F);
      drain();

      // directed: two ways, two victims, one set bit
      set_geometry(4, 1, 2, 2);
      send_access(48'h0000_0000_0000);
      send_access(48'h0000_0000_0100);
      send_access(48'h0000_0000_0000);   // main hit, move to front
      send_access(48'h0000_0000_0200);   // evict LRU into victims
      send_access(48'h0000_0000_0300);   // evict again
      send_access(48'h0000_0000_0408);   // third eviction, oldest victim drops
      send_access(48'h0000_0000_0305);   // main hit on the line of 0x300
      send_access(48'h0000_0000_0010);   // other set
      send_access(48'hFFFF_FFFF_FFF0);
      send_access(48'h8000_0000_0000);
      send_access(48'h0000_0000_0204);   // victim hit on the older entry
      drain();

      // directed: ways of zero and out-of-range registers
      set_geometry(31, 15, 0, 15);
      send_access(48'h0001_0000_0000);
      send_access(48'h0002_0000_0000);
      send_access(48'h0001_0000_0000);
      pause(3);
      send_access(48'h0001_0000_ABCD);
      drain();

      // random phases over a spread of geometries
      for (p = 0; p < 8; p++) begin
         case (p)
            0: set_geometry(0, 0, 1, 0);
            1: set_geometry(16, 8, 8, 8);
            2: set_geometry(0, 8, 8, 8);       // sets share line storage
            3: set_geometry(4, 4, 4, 0);
            4: set_geometry(2, 3, 3, 1);
            5: set_geometry(31, 15, 15, 15);
            6: set_geometry($urandom_range(0, 31), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 15));
            default: set_geometry(6, 2, 2, 4);
         endcase
         random_phase(180);
      end

      drain();
      repeat (60) @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
